[hw/rtl/assert_macros.svh]
// Assertion macros shared by the escape-time colorizer RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/mec_pkg.sv]
// Types and fixed constants of the escape-time colorizer.
// No dependencies; used by mec_ctrl, mec_datapath and the top level.
`timescale 1ns / 1ps

package mec_pkg;

    localparam int PIXEL_W     = 12;
    localparam int COUNT_W     = 7;
    localparam int CHAN_W      = 8;
    localparam int ORIGIN_W    = 32;
    localparam int STEP_W      = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    // origin + 4095 * step needs 44 signed bits
    localparam int C_W         = 45;
    localparam int MUL_LIMB_W  = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG   = 2'd3;

    localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 32'hE000_0000;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 31'h0010_0000;

    localparam int THRESH_LOW  = 16;
    localparam int THRESH_MID  = 32;
    localparam int THRESH_HIGH = 48;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;      // capture pixel, form c, clear z
        logic mul_step;   // one limb of the three products
        logic update;     // z <= z^2 + c, count++
        logic load_out;   // color into the output register
    } cmd_t;

    typedef struct packed {
        logic limb_last;
        logic escaped;
        logic iter_last;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/mec_ctrl.sv]
// Sequencer of the escape-time colorizer: accepts a pixel, steps the
// multiply/update loop and hands the result to the output register. Uses mec_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mec_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mec_pkg::status_t status,
    output mec_pkg::cmd_t    cmd
);
    import mec_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (status.limb_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.escaped || status.iter_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = !status.escaped;
            end
            ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_NEXT(a_escape_ends, clk, rst_n, (state_reg == ST_UPDATE) && status.escaped, state_reg == ST_FINISH)
    `ASSERT_ALWAYS(a_single_cmd, clk, rst_n, $onehot0({cmd.start, cmd.mul_step, cmd.update, cmd.load_out}))

endmodule

[hw/rtl/mec_datapath.sv]
// Datapath of the escape-time colorizer: config registers, c mapping, the
// limb-serial squarer/multiplier, z update with clamp, coloring, output register.
// Uses mec_pkg; driven by mec_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mec_datapath #(
    parameter int MAX_ITERATIONS = 64,
    parameter int FRACTION_BITS  = 28
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mec_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [mec_pkg::PIXEL_W-1:0]      pixel_x,
    input  logic [mec_pkg::PIXEL_W-1:0]      pixel_y,
    input  mec_pkg::cmd_t                    cmd,
    output mec_pkg::status_t                 status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mec_pkg::COUNT_W-1:0]      iteration_count,
    output logic [mec_pkg::CHAN_W-1:0]       red,
    output logic [mec_pkg::CHAN_W-1:0]       green,
    output logic [mec_pkg::CHAN_W-1:0]       blue
);
    import mec_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int M    = F + 2;                         // |z| component magnitude
    localparam int LIMB = MUL_LIMB_W;
    localparam int L    = (M + LIMB - 1) / LIMB;         // limbs per product
    localparam int YW   = L * LIMB;
    localparam int PW   = M + YW;
    localparam int AW   = F + 3;                         // signed, holds +-2.0
    localparam int SQW  = F + 4;
    localparam int SW   = ((SQW > C_W) ? SQW : C_W) + 2;
    localparam int NW   = $clog2(MAX_ITERATIONS + 1);
    localparam int LCW  = $clog2(L + 1);

    localparam logic [SQW:0]          FOUR   = (SQW + 1)'(1) << (F + 2);
    localparam logic signed [SW-1:0]  LIM    = SW'(1) << (F + 1);
    localparam logic signed [AW-1:0]  A_LIM  = AW'(1) << (F + 1);

    // configuration
    logic signed [ORIGIN_W-1:0] origin_real_reg;
    logic signed [ORIGIN_W-1:0] origin_imag_reg;
    logic [STEP_W-1:0]          step_real_reg;
    logic [STEP_W-1:0]          step_imag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_real_reg <= ORIGIN_RESET;
            origin_imag_reg <= ORIGIN_RESET;
            step_real_reg   <= STEP_RESET;
            step_imag_reg   <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_REAL: origin_real_reg <= cfg_data;
                REG_ORIGIN_IMAG: origin_imag_reg <= cfg_data;
                REG_STEP_REAL:   step_real_reg   <= cfg_data[STEP_W-1:0];
                REG_STEP_IMAG:   step_imag_reg   <= cfg_data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // c = origin + pixel * step
    logic [PIXEL_W+STEP_W-1:0] off_real;
    logic [PIXEL_W+STEP_W-1:0] off_imag;
    logic signed [C_W-1:0]     c_real_next;
    logic signed [C_W-1:0]     c_imag_next;
    logic signed [C_W-1:0]     c_real_reg;
    logic signed [C_W-1:0]     c_imag_reg;

    assign off_real    = pixel_x * step_real_reg;
    assign off_imag    = pixel_y * step_imag_reg;
    assign c_real_next = C_W'(origin_real_reg) + C_W'(off_real);
    assign c_imag_next = C_W'(origin_imag_reg) + C_W'(off_imag);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            c_real_reg <= c_real_next;
            c_imag_reg <= c_imag_next;
        end
    end

    // z and iteration count
    logic signed [AW-1:0] a_reg;
    logic signed [AW-1:0] b_reg;
    logic signed [AW-1:0] a_next;
    logic signed [AW-1:0] b_next;
    logic [NW-1:0]        n_reg;
    logic [LCW-1:0]       cnt_reg;
    logic [M-1:0]         mag_a;
    logic [M-1:0]         mag_b;

    assign mag_a = a_reg[AW-1] ? M'(-a_reg) : M'(a_reg);
    assign mag_b = b_reg[AW-1] ? M'(-b_reg) : M'(b_reg);

    // limb-serial products, most significant limb of the y operand first
    logic [YW-1:0]        ysa_reg;
    logic [YW-1:0]        ysb_reg;
    logic [YW-1:0]        ya_cur;
    logic [YW-1:0]        yb_cur;
    logic [LIMB-1:0]      limb_a;
    logic [LIMB-1:0]      limb_b;
    logic [M+LIMB-1:0]    p_aa;
    logic [M+LIMB-1:0]    p_bb;
    logic [M+LIMB-1:0]    p_ab;
    logic [PW-1:0]        acc_aa_reg;
    logic [PW-1:0]        acc_bb_reg;
    logic [PW-1:0]        acc_ab_reg;
    logic [PW-1:0]        acc_aa_next;
    logic [PW-1:0]        acc_bb_next;
    logic [PW-1:0]        acc_ab_next;
    logic                 first_limb;

    assign first_limb = (cnt_reg == '0);
    assign ya_cur     = first_limb ? YW'(mag_a) : ysa_reg;
    assign yb_cur     = first_limb ? YW'(mag_b) : ysb_reg;
    assign limb_a     = ya_cur[YW-1 -: LIMB];
    assign limb_b     = yb_cur[YW-1 -: LIMB];
    assign p_aa       = mag_a * limb_a;
    assign p_bb       = mag_b * limb_b;
    assign p_ab       = mag_a * limb_b;

    assign acc_aa_next = first_limb ? PW'(p_aa) : (acc_aa_reg << LIMB) + PW'(p_aa);
    assign acc_bb_next = first_limb ? PW'(p_bb) : (acc_bb_reg << LIMB) + PW'(p_bb);
    assign acc_ab_next = first_limb ? PW'(p_ab) : (acc_ab_reg << LIMB) + PW'(p_ab);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            ysa_reg    <= ya_cur << LIMB;
            ysb_reg    <= yb_cur << LIMB;
            acc_aa_reg <= acc_aa_next;
            acc_bb_reg <= acc_bb_next;
            acc_ab_reg <= acc_ab_next;
        end
    end

    // escape test and z update, truncated toward zero on magnitudes
    logic [SQW-1:0]        a2;
    logic [SQW-1:0]        b2;
    logic [SQW-1:0]        ab2;
    logic [SQW:0]          sq_sum;
    logic signed [SW-1:0]  ab2_s;
    logic signed [SW-1:0]  sum_a;
    logic signed [SW-1:0]  sum_b;
    logic                  neg_ab;

    assign a2     = acc_aa_reg[F +: SQW];
    assign b2     = acc_bb_reg[F +: SQW];
    assign ab2    = acc_ab_reg[F-1 +: SQW];
    assign sq_sum = (SQW + 1)'(a2) + (SQW + 1)'(b2);
    assign neg_ab = a_reg[AW-1] ^ b_reg[AW-1];
    assign ab2_s  = neg_ab ? -SW'(ab2) : SW'(ab2);
    assign sum_a  = SW'(a2) - SW'(b2) + SW'(c_real_reg);
    assign sum_b  = ab2_s + SW'(c_imag_reg);

    always_comb
    begin
        priority if (sum_a > LIM)
        begin
            a_next = AW'(LIM);
        end
        else if (sum_a < -LIM)
        begin
            a_next = AW'(-LIM);
        end
        else
        begin
            a_next = AW'(sum_a);
        end
    end

    always_comb
    begin
        priority if (sum_b > LIM)
        begin
            b_next = AW'(LIM);
        end
        else if (sum_b < -LIM)
        begin
            b_next = AW'(-LIM);
        end
        else
        begin
            b_next = AW'(sum_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            b_reg   <= '0;
            n_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            a_reg   <= '0;
            b_reg   <= '0;
            n_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.update)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            n_reg   <= n_reg + NW'(1);
            cnt_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            cnt_reg <= cnt_reg + LCW'(1);
        end
    end

    // banded coloring, every channel mod 256
    logic [CHAN_W-1:0] n8;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;

    assign n8 = CHAN_W'(n_reg);

    always_comb
    begin
        priority if (n_reg < NW'(THRESH_LOW))
        begin
            red_next   = CHAN_FULL;
            green_next = CHAN_ZERO - ((CHAN_W'(THRESH_LOW) - n8) << 4);
            blue_next  = CHAN_ZERO;
        end
        else if (n_reg < NW'(THRESH_MID))
        begin
            red_next   = ((CHAN_W'(THRESH_MID) - n8) << 4) - CHAN_W'(1);
            green_next = CHAN_FULL;
            blue_next  = CHAN_ZERO;
        end
        else if (n_reg < NW'(THRESH_HIGH))
        begin
            red_next   = CHAN_ZERO;
            green_next = CHAN_FULL;
            blue_next  = CHAN_FULL - CHAN_W'(1) - ((CHAN_W'(THRESH_HIGH) - n8) << 4);
        end
        else if (n_reg < NW'(MAX_ITERATIONS))
        begin
            red_next   = CHAN_ZERO;
            green_next = ((CHAN_W'(MAX_ITERATIONS) - n8) << 4) - CHAN_W'(1);
            blue_next  = CHAN_FULL;
        end
        else
        begin
            red_next   = CHAN_ZERO;
            green_next = CHAN_ZERO;
            blue_next  = CHAN_ZERO;
        end
    end

    // output register
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [CHAN_W-1:0]   out_red_reg;
    logic [CHAN_W-1:0]   out_green_reg;
    logic [CHAN_W-1:0]   out_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_count_reg <= COUNT_W'(n_reg);
            out_red_reg   <= red_next;
            out_green_reg <= green_next;
            out_blue_reg  <= blue_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = out_count_reg;
    assign red             = out_red_reg;
    assign green           = out_green_reg;
    assign blue            = out_blue_reg;

    assign status.limb_last = (cnt_reg == LCW'(L - 1));
    assign status.escaped   = (sq_sum >= FOUR);
    assign status.iter_last = (n_reg == NW'(MAX_ITERATIONS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, n_reg <= NW'(MAX_ITERATIONS))
    `ASSERT_ALWAYS(a_z_clamped, clk, rst_n, (a_reg <= A_LIM) && (a_reg >= -A_LIM) && (b_reg <= A_LIM) && (b_reg >= -A_LIM))
    `ASSERT_IMPLIES(a_out_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_reg || out_ready)

endmodule

[hw/rtl/mandelbrot_escape_time_colorizer.sv]
// Mandelbrot escape-time colorizer: one pixel in, one colored result out.
//
// s_* channel: one pixel coordinate per transaction. m_* channel: one result
// per pixel, in order. cfg_* port: write origin and step registers while idle;
// index 0 origin_real, 1 origin_imag, 2 step_real, 3 step_imag.
// Arithmetic is signed fixed point with FRACTION_BITS fraction bits.
// Timing: one pixel at a time. The pixel-to-c mapping happens in the accept
// cycle. Each iteration steps through the L limbs of the limb-serial multiplier
// (L = ceil((FRACTION_BITS+2)/32), 1 by default), then through one update step.
// The next pixel can be accepted from the cycle after the result is loaded.
// The output register lets the next pixel be accepted while a result waits.
// If the receiver stalls, the block finishes the pixel in flight and then
// holds it until the waiting result is taken.
// Reset (rst_n low, asynchronous) empties the block and restores the
// register defaults (origin -2 - 2i, step 2^-8).
`timescale 1ns / 1ps

module mandelbrot_escape_time_colorizer #(
    parameter int MAX_ITERATIONS = 64,
    parameter int FRACTION_BITS  = 28
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mec_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mec_pkg::IN_TDATA_W-1:0]     s_tdata,   // pixel_x[11:0], pixel_y[23:12]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mec_pkg::OUT_TDATA_W-1:0]    m_tdata    // count[6:0], red[14:7],
                                                          // green[22:15], blue[30:23], 0
);
    import mec_pkg::*;

    cmd_t                cmd;
    status_t             status;
    logic [COUNT_W-1:0]  iteration_count;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;

    mec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mec_datapath #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pixel_x         (s_tdata[PIXEL_W-1:0]),
        .pixel_y         (s_tdata[2*PIXEL_W-1:PIXEL_W]),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .iteration_count (iteration_count),
        .red             (red),
        .green           (green),
        .blue            (blue)
    );

    assign m_tdata = {1'b0, blue, green, red, iteration_count};

endmodule

[sim/mandelbrot_escape_time_colorizer_tb.sv]
// Self-checking bench for the escape-time colorizer: random bursty pixel stream in,
// results checked in order against an in-bench fixed-point predictor. Needs mec_pkg.
`timescale 1ns / 1ps

module mandelbrot_escape_time_colorizer_tb;

    import mec_pkg::*;

    localparam int ITER_CAP     = 64;
    localparam int FRAC_BITS    = 28;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLDOFF_AT   = 150;
    localparam int HOLDOFF_LEN  = 300;
    localparam int DRAIN_CYCLES = 2 * ITER_CAP + 12;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } pixel_color_t;

    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // shadow copy of the block's registers
    logic signed [ORIGIN_W-1:0] origin_re = ORIGIN_RESET;
    logic signed [ORIGIN_W-1:0] origin_im = ORIGIN_RESET;
    logic [STEP_W-1:0]          step_re = STEP_RESET;
    logic [STEP_W-1:0]          step_im = STEP_RESET;

    logic [IN_TDATA_W-1:0] pixel_backlog[$];
    pixel_color_t          expected_colors[$];

    int       error_count = 0;
    int       pixels_sent = 0;
    int       results_seen = 0;
    int       settings_count = 1;
    int       bounded_count = 0;
    int       min_count = ITER_CAP;
    int       max_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       holdoff_left = 0;
    bit       holdoff_done = 1'b0;
    int       stall_tick = 0;
    int       quiet_cycles = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    pixel_color_t got, want;

    mandelbrot_escape_time_colorizer #(
        .MAX_ITERATIONS(ITER_CAP),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint saturate_two(longint v);
        longint lim;
        lim = longint'(2) << FRAC_BITS;
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic pixel_color_t escape_color(logic [PIXEL_W-1:0] px,
                                                  logic [PIXEL_W-1:0] py);
        longint          cr, ci, za, zb, a2, b2, ab2, four;
        longint unsigned ma, mb;
        int unsigned     n, r, g, b;
        bit              escaped;
        pixel_color_t    res;
        cr = longint'(origin_re) + longint'(px) * longint'(step_re);
        ci = longint'(origin_im) + longint'(py) * longint'(step_im);
        four = longint'(4) << FRAC_BITS;
        za = 0;
        zb = 0;
        n = 0;
        escaped = 1'b0;
        while (n < ITER_CAP && !escaped)
        begin
            ma = (za < 0) ? -za : za;
            mb = (zb < 0) ? -zb : zb;
            a2 = (ma * ma) >> FRAC_BITS;
            b2 = (mb * mb) >> FRAC_BITS;
            if (a2 + b2 >= four)
                escaped = 1'b1;
            else
            begin
                ab2 = (ma * mb) >> (FRAC_BITS - 1);
                if ((za < 0) != (zb < 0))
                    ab2 = -ab2;
                za = saturate_two(a2 - b2 + cr);
                zb = saturate_two(ab2 + ci);
                n++;
            end
        end
        // later bands override earlier ones; channels wrap mod 256
        r = 0;
        g = 0;
        b = 0;
        if (n < ITER_CAP)
        begin
            g = (ITER_CAP - n) * 16 - 1;
            b = CHAN_FULL;
        end
        if (n < THRESH_HIGH)
        begin
            g = CHAN_FULL;
            b = 255 - (THRESH_HIGH - n) * 16 - 1;
        end
        if (n < THRESH_MID)
        begin
            r = (THRESH_MID - n) * 16 - 1;
            g = CHAN_FULL;
            b = CHAN_ZERO;
        end
        if (n < THRESH_LOW)
        begin
            r = CHAN_FULL;
            g = 255 - ((THRESH_LOW - n) * 16 - 1);
            b = CHAN_ZERO;
        end
        res.count = n[COUNT_W-1:0];
        res.red   = r[CHAN_W-1:0];
        res.green = g[CHAN_W-1:0];
        res.blue  = b[CHAN_W-1:0];
        return res;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_colors.push_back(escape_color(s_tdata[PIXEL_W-1:0],
                                                       s_tdata[2*PIXEL_W-1:PIXEL_W]));
                pixels_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    s_tdata  <= pixel_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each result, then picks next tready from its stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            stall_tick++;
            if (m_tvalid && m_tready)
            begin
                got.count = m_tdata[6:0];
                got.red   = m_tdata[14:7];
                got.green = m_tdata[22:15];
                got.blue  = m_tdata[30:23];
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: unexpected result: count %0d rgb %02h %02h %02h",
                             $realtime, got.count, got.red, got.green, got.blue);
                    error_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (got.count !== want.count || got.red !== want.red ||
                        got.green !== want.green || got.blue !== want.blue)
                    begin
                        $display("%0t: mismatch: expected count %0d rgb %02h %02h %02h, got count %0d rgb %02h %02h %02h",
                                 $realtime, want.count, want.red, want.green, want.blue,
                                 got.count, got.red, got.green, got.blue);
                        error_count++;
                    end
                    if (want.count == ITER_CAP)
                        bounded_count++;
                    if (want.count < min_count)
                        min_count = want.count;
                    if (want.count > max_count)
                        max_count = want.count;
                end
                results_seen++;
            end
            if (results_seen == HOLDOFF_AT && !holdoff_done)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            else
                case (rx_mode)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: m_tready <= (stall_tick % 7 >= 3);
                    default:     m_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, expected_colors.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_ORIGIN_REAL: origin_re = value;
            REG_ORIGIN_IMAG: origin_im = value;
            REG_STEP_REAL:   step_re = value[STEP_W-1:0];
            REG_STEP_IMAG:   step_im = value[STEP_W-1:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_view(logic [31:0] o_re, logic [31:0] o_im,
                            logic [31:0] s_re, logic [31:0] s_im);
        program_reg(REG_ORIGIN_REAL, o_re);
        program_reg(REG_ORIGIN_IMAG, o_im);
        program_reg(REG_STEP_REAL, s_re);
        program_reg(REG_STEP_IMAG, s_im);
        settings_count++;
    endtask

    // sampled between edges so the sender's pending updates have settled
    task automatic wait_drained(int extra);
        do
            @(negedge clk);
        while (pixel_backlog.size() != 0 || s_tvalid || expected_colors.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    initial
    begin
        int px_line[12];
        int o_re, o_im;

        px_line = '{0, 256, 512, 576, 577, 578, 580, 584, 592, 608, 700, 4095};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset view: c = -2 - 2i + (px + i py) / 256
        pixel_backlog.push_back({12'd0, 12'd0});
        pixel_backlog.push_back({12'd4095, 12'd4095});
        pixel_backlog.push_back({12'd512, 12'd512});
        pixel_backlog.push_back({12'd512, 12'd576});
        pixel_backlog.push_back({12'h555, 12'hAAA});
        pixel_backlog.push_back({12'hAAA, 12'h555});
        wait_drained(4);

        // real axis through the cusp at 0.25: counts sweep from high to low
        set_view(32'hE000_0000, 32'h0, 32'd1 << 20, 32'h0);
        foreach (px_line[i])
            pixel_backlog.push_back({12'($urandom_range(0, 4095)), 12'(px_line[i])});
        wait_drained(4);

        // register extremes; bit 31 written to the 31-bit steps must be dropped
        set_view(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        pixel_backlog.push_back({12'd4095, 12'd4095});
        pixel_backlog.push_back({12'd0, 12'd4095});
        wait_drained(4);
        set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        pixel_backlog.push_back({12'd0, 12'd0});
        pixel_backlog.push_back({12'd4095, 12'd4095});
        wait_drained(4);
        set_view(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        pixel_backlog.push_back({12'd0, 12'd4095});
        pixel_backlog.push_back({12'd1, 12'd0});
        wait_drained(4);
        set_view(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);
        pixel_backlog.push_back({12'd0, 12'd4095});
        wait_drained(4);

        // random views, mostly framing the set so counts spread over every band
        for (int ph = 0; ph < 6; ph++)
        begin
            rx_mode = rx_mode_t'(ph % 4);
            if (ph == 5)
                set_view($urandom, $urandom, $urandom, $urandom);
            else
            begin
                o_re = -671088640 + int'($urandom_range(0, 805306368));
                o_im = -402653184 + int'($urandom_range(0, 536870912));
                set_view(o_re, o_im,
                         {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1 << 17))},
                         {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1 << 17))});
            end
            for (int k = 0; k < 105; k++)
                pixel_backlog.push_back(24'($urandom));
            wait_drained(4);
        end

        rx_mode = RX_ALWAYS;
        wait_drained(DRAIN_CYCLES);
        $display("Checked %0d of %0d pixels over %0d register settings.",
                 results_seen, pixels_sent, settings_count);
        $display("Escape counts spanned %0d to %0d; %0d pixels stayed bounded.",
                 min_count, max_count, bounded_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
